// ===== rtl/deque_with_sorted_insert_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the deque with sorted insert
// Shorthand for clocked implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SORTED_INSERT_UNIT_MACROS_SVH
`define DEQUE_WITH_SORTED_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DWSI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication, disabled during reset.
`define DWSI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// ===== rtl/dwsi_pkg.sv =====
// ----------------------------------------------------------------------------
// dwsi_pkg
// Shared types, codes and helper functions of the deque with sorted insert.
// ----------------------------------------------------------------------------
package dwsi_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int VALUE_W       = 64;
   localparam int KIND_W        = 3;
   localparam int POS_W         = 6;
   localparam int MODE_W        = 2;
   localparam int RADIX_W       = 3;   // read tree: 8 inputs per node

   typedef enum logic [KIND_W-1:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_PEEK       = 3'd5
   } op_kind_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_TAKE_LEFT,
      CELL_TAKE_RIGHT
   } cell_cmd_type;

   typedef struct packed {
      cell_cmd_type      cmd;
      logic [MODE_W-1:0] order_mode;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DONE
   } state_type;

   // True when a stays behind b under the given ordering.
   function automatic logic order_not_before(input logic [VALUE_W-1:0] a,
                                             input logic [VALUE_W-1:0] b,
                                             input logic [MODE_W-1:0]  mode);
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] y;
      x = a;
      y = b;
      if (!mode[0]) begin
         x[VALUE_W-1] = ~x[VALUE_W-1];
         y[VALUE_W-1] = ~y[VALUE_W-1];
      end
      if (mode[1]) begin
         return x <= y;
      end
      return x >= y;
   endfunction

   // Number of radix-8 levels needed to cover depth leaves.
   function automatic int rt_levels(input int depth);
      int lv;
      int span;
      lv   = 1;
      span = 8;
      while (span < depth) begin
         span = span * 8;
         lv   = lv + 1;
      end
      return lv;
   endfunction

   // Index of the first node of level lvl in the flat node array.
   function automatic int rt_offset(input int levels, input int lvl);
      int acc;
      acc = 0;
      for (int k = 0; k < lvl; k++) begin
         acc = acc + (1 << (RADIX_W * (levels - 1 - k)));
      end
      return acc;
   endfunction

endpackage

// ===== rtl/dwsi_cell.sv =====
// ----------------------------------------------------------------------------
// dwsi_cell
// One storage cell of the entry chain: holds one entry, loads the new entry
// or takes its left or right neighbor, and compares the new entry to its own.
// ----------------------------------------------------------------------------
module dwsi_cell (
   input  logic                          clock,
   input  dwsi_pkg::cell_ctrl_type       ctrl,
   input  logic [dwsi_pkg::VALUE_W-1:0]  new_value,
   input  logic [dwsi_pkg::VALUE_W-1:0]  left_value,
   input  logic [dwsi_pkg::VALUE_W-1:0]  right_value,
   output logic [dwsi_pkg::VALUE_W-1:0]  value,
   output logic                          not_before
);

   logic [dwsi_pkg::VALUE_W-1:0] value_ff;
   logic [dwsi_pkg::VALUE_W-1:0] value_in;

   always_comb begin
      unique case (ctrl.cmd)
         dwsi_pkg::CELL_LOAD:       value_in = new_value;
         dwsi_pkg::CELL_TAKE_LEFT:  value_in = left_value;
         dwsi_pkg::CELL_TAKE_RIGHT: value_in = right_value;
         default:                   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign not_before = dwsi_pkg::order_not_before(new_value, value_ff, ctrl.order_mode);

endmodule

// ===== rtl/dwsi_rdtree.sv =====
// ----------------------------------------------------------------------------
// dwsi_rdtree
// Registered radix-8 select tree that reads one cell at an index.
// The index must hold steady; every level of the tree is registered.
// ----------------------------------------------------------------------------
module dwsi_rdtree #(
   parameter int DEPTH = dwsi_pkg::DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic [dwsi_pkg::VALUE_W-1:0]  cell_value [DEPTH],
   input  logic [$clog2(DEPTH)-1:0]      rd_index,
   output logic [dwsi_pkg::VALUE_W-1:0]  rd_value
);

   localparam int LEVELS = dwsi_pkg::rt_levels(DEPTH);
   localparam int SEL_W  = dwsi_pkg::RADIX_W * LEVELS;
   localparam int FANIN  = 1 << dwsi_pkg::RADIX_W;
   localparam int TOTAL  = dwsi_pkg::rt_offset(LEVELS, LEVELS);

   logic [dwsi_pkg::VALUE_W-1:0] node_ff [TOTAL];
   logic [dwsi_pkg::VALUE_W-1:0] node_in [TOTAL];
   logic [SEL_W-1:0]             sel;

   assign sel = SEL_W'(rd_index);

   for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
      localparam int N    = 1 << (dwsi_pkg::RADIX_W * (LEVELS - 1 - l));
      localparam int OFF  = dwsi_pkg::rt_offset(LEVELS, l);
      localparam int POFF = dwsi_pkg::rt_offset(LEVELS, l - 1);
      for (genvar j = 0; j < N; j++) begin : g_node
         logic [dwsi_pkg::VALUE_W-1:0] kid [FANIN];
         for (genvar s = 0; s < FANIN; s++) begin : g_kid
            if (l == 0) begin : g_leaf
               if (j * FANIN + s < DEPTH) begin : g_cell
                  assign kid[s] = cell_value[j * FANIN + s];
               end else begin : g_pad
                  assign kid[s] = '0;
               end
            end else begin : g_inner
               assign kid[s] = node_ff[POFF + j * FANIN + s];
            end
         end
         assign node_in[OFF + j] = kid[sel[dwsi_pkg::RADIX_W * l +: dwsi_pkg::RADIX_W]];
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
   end

   assign rd_value = node_ff[TOTAL-1];

endmodule

// ===== rtl/deque_with_sorted_insert_unit.sv =====
// ----------------------------------------------------------------------------
// deque_with_sorted_insert_unit
// Bounded double-ended queue of 64-bit entries built as a chain of cells,
// with push/pop at both ends, order-stable sorted insert and indexed peek.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (kind, entry value, position) with valid/ready.
//   rsp_* returns one response per request: popped/peeked value and its valid
//   flag, the full flag, occupancy and the front and back entries afterwards.
//   csr_write_enable/csr_write_data set the sorted insert ordering; write it
//   only while no request is in flight.
// Timing (receiver ready):
//   Push, push front, pop front, insert, a pop back that empties or finds an
//   empty queue, and a peek that misses: the request passes ST_DONE into the
//   output register, where rsp_valid rises, and req_ready returns in ST_IDLE.
//   Pop back and a peek that hits read a cell through the registered select
//   tree (LEVELS = ceil(log8(DEPTH)), 2 for 64 entries) in ST_READ first.
//   A new request is accepted only once the previous one has left ST_DONE.
//   The chain shifts/loads the entries a request moves in the acceptance cycle.
// Reset: the queue is empty and ordering is signed ascending; cell contents
//   are not cleared. A stalled response is held in the output register while
//   one further request can be accepted and finished into a holding stage.
// ----------------------------------------------------------------------------
`include "deque_with_sorted_insert_unit_macros.svh"
module deque_with_sorted_insert_unit #(
   parameter int DEPTH = dwsi_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dwsi_pkg::KIND_W-1:0]          req_kind,
   input  logic signed [dwsi_pkg::VALUE_W-1:0]  req_entry_value,
   input  logic [dwsi_pkg::POS_W-1:0]           req_position,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [dwsi_pkg::VALUE_W-1:0]  rsp_result_value,
   output logic                                 rsp_result_valid,
   output logic                                 rsp_full_error,
   output logic [$clog2(DEPTH+1)-1:0]           rsp_occupancy,
   output logic signed [dwsi_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [dwsi_pkg::VALUE_W-1:0]  rsp_back_value,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [dwsi_pkg::MODE_W-1:0]          csr_write_data
);

   localparam int CW        = $clog2(DEPTH + 1);
   localparam int AW        = $clog2(DEPTH);
   localparam int VW        = dwsi_pkg::VALUE_W;
   localparam int RD_LEVELS = dwsi_pkg::rt_levels(DEPTH);
   localparam int RD_CNT_W  = $clog2(RD_LEVELS + 1);

   // ---------------------------------------------------------------- state
   dwsi_pkg::state_type        state_ff, state_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [VW-1:0]              back_ff, back_in;       // mirrors the back cell
   logic [dwsi_pkg::MODE_W-1:0] mode_ff, mode_in;

   // holding stage for the finished request
   logic [VW-1:0]              res_value_ff, res_value_in;
   logic                       res_valid_ff, res_valid_in;
   logic                       full_err_ff, full_err_in;

   // read sequencing
   logic [AW-1:0]              rd_idx_ff, rd_idx_in;
   logic [RD_CNT_W-1:0]        rd_cnt_ff, rd_cnt_in;
   logic                       rd_peek_ff, rd_peek_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]              rsp_value_ff, rsp_value_in;
   logic                       rsp_rvalid_ff, rsp_rvalid_in;
   logic                       rsp_err_ff, rsp_err_in;
   logic [CW-1:0]              rsp_occ_ff, rsp_occ_in;
   logic [VW-1:0]              rsp_front_ff, rsp_front_in;
   logic [VW-1:0]              rsp_back_ff, rsp_back_in;

   // ---------------------------------------------------------------- chain
   logic [VW-1:0]              cell_value [DEPTH];
   logic [DEPTH-1:0]           cell_nb;        // new entry not before cell
   logic [DEPTH-1:0]           cell_live;      // cell holds an entry
   logic [DEPTH-1:0]           hit_vec;        // live and scan would stop here
   logic [DEPTH-1:0]           tail;           // no stop at or behind cell i
   logic [DEPTH-1:0]           tail_prev;
   dwsi_pkg::cell_ctrl_type    cell_ctrl [DEPTH];

   logic [VW-1:0]              rd_value;

   // ---------------------------------------------------------------- decode
   dwsi_pkg::op_kind_type      req_op;
   dwsi_pkg::cell_cmd_type     op_cmd [DEPTH];
   logic [VW-1:0]              op_res_value;
   logic                       op_res_valid;
   logic                       op_full;
   logic [CW-1:0]              op_count;
   logic [VW-1:0]              op_back;
   logic                       op_read;
   logic [AW-1:0]              op_rd_idx;
   logic                       op_rd_peek;

   logic                       accept;
   logic                       is_full;
   logic                       is_empty;
   logic                       at_back;        // sorted insert lands at the back
   logic                       peek_hit;
   logic                       rd_last;
   logic                       out_free;
   logic                       load_out;

   assign req_op   = dwsi_pkg::op_kind_type'(req_kind);
   assign accept   = req_valid & req_ready;
   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign peek_hit = (32'(req_position) < 32'(count_ff));
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // ---------------------------------------------------------------- cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VW-1:0] left_value;
      logic [VW-1:0] right_value;
      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end

      assign cell_ctrl[i].cmd        = accept ? op_cmd[i] : dwsi_pkg::CELL_HOLD;
      assign cell_ctrl[i].order_mode = mode_ff;

      dwsi_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .new_value   (req_entry_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .not_before  (cell_nb[i])
      );
   end

   // Insert position: the cell right behind the last live cell that the new
   // entry does not precede. Every cell checks its own suffix independently.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_live[i] = (CW'(i) < count_ff);
         hit_vec[i]   = cell_nb[i] & cell_live[i];
      end
      for (int i = 0; i < DEPTH; i++) begin
         tail[i] = ((hit_vec >> i) == '0);
      end
   end

   assign tail_prev = {tail[DEPTH-2:0], 1'b0};
   assign at_back   = is_empty | hit_vec[AW'(count_ff - CW'(1))];

   // ---------------------------------------------------------------- read tree
   dwsi_rdtree #(
      .DEPTH (DEPTH)
   ) u_rdtree (
      .clock      (clock),
      .cell_value (cell_value),
      .rd_index   (rd_idx_ff),
      .rd_value   (rd_value)
   );

   // ---------------------------------------------------------------- request decode
   always_comb begin : p_op_decode
      op_cmd       = '{default: dwsi_pkg::CELL_HOLD};
      op_res_value = '0;
      op_res_valid = 1'b0;
      op_full      = 1'b0;
      op_count     = count_ff;
      op_back      = back_ff;
      op_read      = 1'b0;
      op_rd_idx    = '0;
      op_rd_peek   = 1'b0;

      unique case (req_op)
         dwsi_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
               op_full = 1'b1;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (count_ff == CW'(i)) op_cmd[i] = dwsi_pkg::CELL_LOAD;
               end
               op_count = count_ff + CW'(1);
               op_back  = req_entry_value;
            end
         end
         dwsi_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
               op_full = 1'b1;
            end else begin
               op_cmd[0] = dwsi_pkg::CELL_LOAD;
               for (int i = 1; i < DEPTH; i++) begin
                  op_cmd[i] = dwsi_pkg::CELL_TAKE_LEFT;
               end
               op_count = count_ff + CW'(1);
               op_back  = is_empty ? req_entry_value : back_ff;
            end
         end
         dwsi_pkg::OP_POP_BACK: begin
            if (!is_empty) begin
               op_res_value = back_ff;
               op_res_valid = 1'b1;
               op_count     = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  op_back = '0;
               end else begin
                  // new back sits one cell ahead of the old one
                  op_read   = 1'b1;
                  op_rd_idx = AW'(count_ff - CW'(2));
               end
            end
         end
         dwsi_pkg::OP_POP_FRONT: begin
            if (!is_empty) begin
               op_res_value = cell_value[0];
               op_res_valid = 1'b1;
               op_count     = count_ff - CW'(1);
               for (int i = 0; i < DEPTH - 1; i++) begin
                  op_cmd[i] = dwsi_pkg::CELL_TAKE_RIGHT;
               end
               op_back = (count_ff == CW'(1)) ? '0 : back_ff;
            end
         end
         dwsi_pkg::OP_INSERT: begin
            if (is_full) begin
               op_full = 1'b1;
            end else begin
               for (int i = 0; i < DEPTH; i++) begin
                  if (tail_prev[i]) begin
                     op_cmd[i] = dwsi_pkg::CELL_TAKE_LEFT;
                  end else if (tail[i]) begin
                     op_cmd[i] = dwsi_pkg::CELL_LOAD;
                  end
               end
               op_count = count_ff + CW'(1);
               op_back  = at_back ? req_entry_value : back_ff;
            end
         end
         dwsi_pkg::OP_PEEK: begin
            if (peek_hit) begin
               op_res_valid = 1'b1;
               op_read      = 1'b1;
               op_rd_idx    = AW'(req_position);
               op_rd_peek   = 1'b1;
            end
         end
         default: begin
            // unused codes leave everything as is
         end
      endcase
   end

   // ---------------------------------------------------------------- FSM
   always_comb begin : p_state_next
      state_in = state_ff;
      unique case (state_ff)
         dwsi_pkg::ST_IDLE: begin
            if (accept) state_in = op_read ? dwsi_pkg::ST_READ : dwsi_pkg::ST_DONE;
         end
         dwsi_pkg::ST_READ: begin
            if (rd_last) state_in = dwsi_pkg::ST_DONE;
         end
         dwsi_pkg::ST_DONE: begin
            if (out_free) state_in = dwsi_pkg::ST_IDLE;
         end
         default: state_in = dwsi_pkg::ST_IDLE;
      endcase
   end

   always_comb begin : p_state_out
      req_ready = 1'b0;
      rd_last   = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         dwsi_pkg::ST_IDLE: req_ready = 1'b1;
         dwsi_pkg::ST_READ: rd_last   = (rd_cnt_ff == RD_CNT_W'(RD_LEVELS));
         dwsi_pkg::ST_DONE: load_out  = out_free;
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- datapath next
   always_comb begin : p_data_next
      count_in     = count_ff;
      back_in      = back_ff;
      mode_in      = csr_write_enable ? csr_write_data : mode_ff;
      res_value_in = res_value_ff;
      res_valid_in = res_valid_ff;
      full_err_in  = full_err_ff;
      rd_idx_in    = rd_idx_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_peek_in   = rd_peek_ff;

      if (accept) begin
         count_in     = op_count;
         back_in      = op_back;
         res_value_in = op_res_value;
         res_valid_in = op_res_valid;
         full_err_in  = op_full;
         rd_idx_in    = op_rd_idx;
         rd_cnt_in    = '0;
         rd_peek_in   = op_rd_peek;
      end else if (state_ff == dwsi_pkg::ST_READ) begin
         if (rd_last) begin
            if (rd_peek_ff) res_value_in = rd_value;
            else            back_in      = rd_value;
         end else begin
            rd_cnt_in = rd_cnt_ff + RD_CNT_W'(1);
         end
      end
   end

   // Output register: loads from the holding stage and the settled state.
   always_comb begin : p_out_next
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_rvalid_in = rsp_rvalid_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_back_in   = rsp_back_ff;
      if (load_out) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_rvalid_in = res_valid_ff;
         rsp_err_in    = full_err_ff;
         rsp_occ_in    = count_ff;
         rsp_front_in  = is_empty ? '0 : cell_value[0];
         rsp_back_in   = back_ff;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dwsi_pkg::ST_IDLE;
         count_ff     <= '0;
         back_ff      <= '0;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         back_ff      <= back_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff  <= res_value_in;
      res_valid_ff  <= res_valid_in;
      full_err_ff   <= full_err_in;
      rd_idx_ff     <= rd_idx_in;
      rd_cnt_ff     <= rd_cnt_in;
      rd_peek_ff    <= rd_peek_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_rvalid_ff <= rsp_rvalid_in;
      rsp_err_ff    <= rsp_err_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_back_ff   <= rsp_back_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_valid = rsp_rvalid_ff;
   assign rsp_full_error   = rsp_err_ff;
   assign rsp_occupancy    = rsp_occ_ff;
   assign rsp_front_value  = rsp_front_ff;
   assign rsp_back_value   = rsp_back_ff;

   // ---------------------------------------------------------------- checks
   // occupancy stays within the chain
   `DWSI_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   // a push or insert into a full queue leaves the occupancy alone
   `DWSI_ASSERT_NEXT(a_full_hold, clock, reset, accept && op_full, count_ff == $past(count_ff))
   // the back mirror reads zero whenever the queue is empty
   `DWSI_ASSERT_IMPL(a_back_empty, clock, reset, count_ff == '0, back_ff == '0)

endmodule
